>>> rtl/clos_pkg.sv
package clos_pkg;

	localparam int ADDR_W = 24;
	localparam int WORD_W = 32;
	localparam int CNT_W = 16;
	localparam int OVL_W = 4;
	localparam int ITER_W = 10;
	localparam int ERR_W = 2;
	localparam int ID_W = 8;
	localparam int SIZE_W = 8;
	localparam int STACK_DEPTH_DEF = 8;

	localparam logic [ID_W-1:0] ID_JUMP = 8'h02;
	localparam logic [ID_W-1:0] ID_CALL = 8'h03;
	localparam logic [ID_W-1:0] ID_RET = 8'h04;
	localparam logic [ITER_W-1:0] ITER_RESET = 10'd1000;
	localparam logic [OVL_W-1:0] OVL_MAX = 4'hC;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
	localparam logic [ADDR_W-1:0] RET_OFFSET = 24'd8;

	// Byte address of the max_iterations register.
	localparam logic [1:0] REG_MAX_ITER = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} status_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE  = 2'd0,
		ERR_SIZE  = 2'd1,
		ERR_ITER  = 2'd2,
		ERR_STACK = 2'd3
	} err_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [OVL_W-1:0]  ovl;
		logic [CNT_W-1:0]  sw;
		logic [ITER_W-1:0] iter;
		status_t           status;
		err_t              err;
	} walk_t;

	typedef struct packed {
		logic [ITER_W-1:0] iter;
		logic [ADDR_W-1:0] addr;
	} stk_entry_t;

	localparam int STK_W = $bits(stk_entry_t);

	typedef struct packed {
		logic       push;
		logic       pop;
		stk_entry_t entry;
	} stk_op_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  sw;
		logic [OVL_W-1:0]  ovl;
		logic              done;
		err_t              err;
	} res_t;

	// Command length in bytes; zero marks an unknown id.
	function automatic logic [SIZE_W-1:0] size_of_id(input logic [ID_W-1:0] id);
		logic [SIZE_W-1:0] sz;
		sz = '0;
		case (id)
			8'h01, 8'h02, 8'h04, 8'h06, 8'h0A: sz = 8'd4;
			8'h03, 8'h08: sz = 8'd8;
			8'h05: sz = 8'd16;
			8'h07, 8'h09: sz = 8'd12;
			8'h10, 8'h12, 8'h13, 8'h16, 8'h1B, 8'h1C: sz = 8'd8;
			8'h11, 8'h15, 8'h18: sz = 8'd16;
			8'h14: sz = 8'd12;
			8'h17, 8'h19, 8'h1A: sz = 8'd4;
			8'hC0, 8'hC1, 8'hC2, 8'hC5: sz = 8'd8;
			8'hC3, 8'hC4: sz = 8'd16;
			8'hC6, 8'hC7: sz = 8'd4;
			8'hC8: sz = 8'd32;
			8'hC9: sz = 8'd48;
			8'hCA, 8'hCC: sz = 8'd96;
			8'hCB, 8'hCD: sz = 8'd112;
			8'hCE: sz = 8'd160;
			8'hCF: sz = 8'd176;
			8'hD0, 8'hDB: sz = 8'd16;
			8'hD1, 8'hDA, 8'hDC, 8'hDE: sz = 8'd4;
			8'hD2, 8'hD3, 8'hD5, 8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hDD: sz = 8'd8;
			8'hD4: sz = 8'd12;
			8'hDF: sz = 8'd28;
			8'hE4, 8'hE5: sz = 8'd16;
			8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE6, 8'hE7, 8'hE8, 8'hE9,
			8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF: sz = 8'd8;
			8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
			8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF: sz = 8'd8;
			default: sz = '0;
		endcase
		return sz;
	endfunction

endpackage

>>> rtl/command_list_overlay_switch_counter.sv
// The result of an accepted request is registered into the main or skid slot of the result buffer.
// Throughput: one request per cycle while req_ready is high; decode and next address are combinational.
// A two-entry result buffer keeps req_ready high while one result waits on res_ready.
// Reset (arst_n low): walk idle, counters and overlay cleared, max_iterations = 1000.
// Return stack contents are not cleared; only entries pushed in the current walk are read.
module command_list_overlay_switch_counter #(
	parameter int STACK_DEPTH = clos_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic                              start_req,
	input  logic [clos_pkg::ADDR_W-1:0]       start_address,
	input  logic [clos_pkg::WORD_W-1:0]       command_word,
	// result channel
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [clos_pkg::ADDR_W-1:0]       fetch_address,
	output logic [clos_pkg::CNT_W-1:0]        switch_count,
	output logic [clos_pkg::OVL_W-1:0]        active_overlay,
	output logic                              done_res,
	output logic [clos_pkg::ERR_W-1:0]        error_code,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [1:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import clos_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// Configuration: max_iterations is the only register, at address zero.
	logic [ITER_W-1:0] max_iter_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = 32'(max_iter_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= ITER_RESET;
		end else if (cfg_wr && paddr == REG_MAX_ITER) begin
			max_iter_q <= pwdata[ITER_W-1:0];
		end
	end

	// Walk state.
	walk_t             walk_q;
	walk_t             walk_nxt;
	logic [DW-1:0]     depth_q;
	logic [DW-1:0]     depth_nxt;
	logic [DW-1:0]     depth_d;
	stk_op_t           stk_op;
	stk_entry_t        tos_q;
	logic [STK_W-1:0]  stk_rdata;
	logic [AW-1:0]     stk_raddr;
	logic              acc;

	assign acc = req_valid & req_ready;

	clos_step #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_step (
		.cur           (walk_q),
		.depth         (depth_q),
		.tos           (tos_q),
		.start_req     (start_req),
		.start_address (start_address),
		.command_word  (command_word),
		.max_iterations(max_iter_q),
		.nxt           (walk_nxt),
		.depth_nxt     (depth_nxt),
		.op            (stk_op)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q.addr   <= '0;
			walk_q.ovl    <= '0;
			walk_q.sw     <= '0;
			walk_q.iter   <= '0;
			walk_q.status <= ST_IDLE;
			walk_q.err    <= ERR_NONE;
			depth_q       <= '0;
		end else if (acc) begin
			walk_q  <= walk_nxt;
			depth_q <= depth_nxt;
		end
	end

	// Return stack: the top entry lives in tos_q, and the RAM keeps every entry.
	// The RAM read is aimed at the entry below the next top, so a later pop finds it
	// already registered. A push writes at the current
	// depth while the read points one lower, so the two never collide.
	assign depth_d   = acc ? depth_nxt : depth_q;
	assign stk_raddr = AW'(depth_d - DW'(2));

	clos_ram #(
		.WIDTH(STK_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (acc & stk_op.push),
		.waddr(AW'(depth_q)),
		.wdata(stk_op.entry),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	always_ff @(posedge clk) begin
		if (acc && stk_op.push) begin
			tos_q <= stk_op.entry;
		end else if (acc && stk_op.pop) begin
			tos_q <= stk_entry_t'(stk_rdata);
		end
	end

	// Result buffer: main slot drives the ports, skid slot catches one result
	// while the main slot is stalled. Drop req_ready only when the skid is full.
	res_t res_new;
	res_t main_q;
	res_t skid_q;
	logic main_vld_q;
	logic skid_vld_q;
	logic res_pop;

	assign res_new.addr = walk_nxt.addr;
	assign res_new.sw   = walk_nxt.sw;
	assign res_new.ovl  = walk_nxt.ovl;
	assign res_new.done = (walk_nxt.status == ST_DONE);
	assign res_new.err  = walk_nxt.err;

	assign req_ready = ~skid_vld_q;
	assign res_valid = main_vld_q;
	assign res_pop   = main_vld_q & res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (res_pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (acc) begin
			if (main_vld_q && !res_pop) begin
				skid_vld_q <= 1'b1;
			end else begin
				main_vld_q <= 1'b1;
			end
		end else if (res_pop) begin
			main_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (res_pop) begin
				main_q <= skid_q;
			end
		end else if (acc) begin
			if (main_vld_q && !res_pop) begin
				skid_q <= res_new;
			end else begin
				main_q <= res_new;
			end
		end
	end

	assign fetch_address  = main_q.addr;
	assign switch_count   = main_q.sw;
	assign active_overlay = main_q.ovl;
	assign done_res       = main_q.done;
	assign error_code     = main_q.err;

	// Checks.
	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid slot holds a result while main slot is empty");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("call depth beyond stack size");

	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && stk_op.push) |=> depth_q == $past(depth_q) + DW'(1))
		else $error("push did not advance call depth");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(walk_q.status == ST_DONE && !(acc && start_req)) |=> walk_q.status == ST_DONE)
		else $error("finished walk resumed without a start request");

endmodule

>>> rtl/clos_ram.sv
module clos_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/clos_step.sv
module clos_step #(
	parameter int STACK_DEPTH = 8
) (
	input  clos_pkg::walk_t                       cur,
	input  logic [$clog2(STACK_DEPTH+1)-1:0]      depth,
	input  clos_pkg::stk_entry_t                  tos,
	input  logic                                  start_req,
	input  logic [clos_pkg::ADDR_W-1:0]           start_address,
	input  logic [clos_pkg::WORD_W-1:0]           command_word,
	input  logic [clos_pkg::ITER_W-1:0]           max_iterations,
	output clos_pkg::walk_t                       nxt,
	output logic [$clog2(STACK_DEPTH+1)-1:0]      depth_nxt,
	output clos_pkg::stk_op_t                     op
);
	import clos_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [ID_W-1:0]   id;
	logic [SIZE_W-1:0] sz;
	logic [ITER_W-1:0] lim;
	logic [ITER_W:0]   iter_inc;
	logic [OVL_W-1:0]  ovl;

	assign id       = command_word[WORD_W-1 -: ID_W];
	assign sz       = size_of_id(id);
	assign lim      = (max_iterations == '0) ? ITER_W'(1) : max_iterations;
	assign iter_inc = {1'b0, cur.iter} + (ITER_W+1)'(1);
	assign ovl      = (id[ID_W-1 -: OVL_W] > OVL_MAX) ? OVL_MAX : id[ID_W-1 -: OVL_W];

	always_comb begin
		nxt       = cur;
		depth_nxt = depth;
		op        = '0;
		if (start_req) begin
			nxt.addr   = start_address;
			nxt.ovl    = '0;
			nxt.sw     = '0;
			nxt.iter   = '0;
			nxt.status = ST_WALK;
			nxt.err    = ERR_NONE;
			depth_nxt  = '0;
		end else if (cur.status == ST_WALK) begin
			case (id)
				ID_JUMP: begin
					nxt.addr = command_word[ADDR_W-1:0];
					nxt.iter = iter_inc[ITER_W-1:0];
					if (iter_inc >= {1'b0, lim}) begin
						nxt.status = ST_DONE;
						nxt.err    = ERR_ITER;
					end
				end
				ID_CALL: begin
					if (depth >= DW'(STACK_DEPTH)) begin
						nxt.status = ST_DONE;
						nxt.err    = ERR_STACK;
					end else begin
						op.push       = 1'b1;
						op.entry.addr = cur.addr + RET_OFFSET;
						op.entry.iter = iter_inc[ITER_W-1:0];
						depth_nxt     = depth + DW'(1);
						nxt.iter      = '0;
						nxt.addr      = command_word[ADDR_W-1:0];
					end
				end
				ID_RET: begin
					if (depth == '0) begin
						nxt.status = ST_DONE;
						nxt.err    = ERR_NONE;
					end else begin
						op.pop    = 1'b1;
						depth_nxt = depth - DW'(1);
						nxt.addr  = tos.addr;
						nxt.iter  = tos.iter;
						if (tos.iter >= lim) begin
							nxt.status = ST_DONE;
							nxt.err    = ERR_ITER;
						end
					end
				end
				default: begin
					if (sz == '0) begin
						nxt.status = ST_DONE;
						nxt.err    = ERR_SIZE;
					end else begin
						nxt.addr = cur.addr + ADDR_W'(sz);
						if (ovl != '0 && ovl != cur.ovl) begin
							nxt.ovl = ovl;
							if (cur.sw != CNT_MAX) begin
								nxt.sw = cur.sw + CNT_W'(1);
							end
						end
						nxt.iter = iter_inc[ITER_W-1:0];
						if (iter_inc >= {1'b0, lim}) begin
							nxt.status = ST_DONE;
							nxt.err    = ERR_ITER;
						end
					end
				end
			endcase
		end
	end

endmodule

>>> dv/tb_command_list_overlay_switch_counter.sv
module tb_command_list_overlay_switch_counter;
	timeunit 1ns;
	timeprecision 1ps;

	import clos_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int RET_DEPTH = STACK_DEPTH_DEF;
	// Room for about 1100 requests under the longest idle bursts.
	localparam int CYCLE_LIMIT = 100000;

	// Command lengths in bytes, one row per high nibble of the id, entry 0 first.
	localparam logic [127:0] LEN_ROW_0 = {8'd0, 8'd4, 8'd4, 8'd8, 8'd4, 8'd16, 8'd4, 8'd12,
		8'd8, 8'd12, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
	localparam logic [127:0] LEN_ROW_1 = {8'd8, 8'd16, 8'd8, 8'd8, 8'd12, 8'd16, 8'd8, 8'd4,
		8'd16, 8'd4, 8'd4, 8'd8, 8'd8, 8'd0, 8'd0, 8'd0};
	localparam logic [127:0] LEN_ROW_C = {8'd8, 8'd8, 8'd8, 8'd16, 8'd16, 8'd8, 8'd4, 8'd4,
		8'd32, 8'd48, 8'd96, 8'd112, 8'd96, 8'd112, 8'd160, 8'd176};
	localparam logic [127:0] LEN_ROW_D = {8'd16, 8'd4, 8'd8, 8'd8, 8'd12, 8'd8, 8'd8, 8'd8,
		8'd8, 8'd8, 8'd4, 8'd16, 8'd4, 8'd8, 8'd4, 8'd28};
	localparam logic [127:0] LEN_ROW_E = {8'd8, 8'd8, 8'd8, 8'd8, 8'd16, 8'd16, 8'd8, 8'd8,
		8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8};
	localparam logic [127:0] LEN_ROW_F = {16{8'd8}};

	typedef struct {
		logic              start;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] word;
	} walk_req_t;

	// DUT pins, every input known from time zero
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic              start_req = 1'b0;
	logic [ADDR_W-1:0] start_address = '0;
	logic [WORD_W-1:0] command_word = '0;
	logic              res_valid;
	logic              res_ready = 1'b1;
	logic [ADDR_W-1:0] fetch_address;
	logic [CNT_W-1:0]  switch_count;
	logic [OVL_W-1:0]  active_overlay;
	logic              done_res;
	logic [ERR_W-1:0]  error_code;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [1:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	// Shadow walker state
	logic [ITER_W-1:0] iter_limit_reg = ITER_RESET;
	logic [ADDR_W-1:0] walk_addr = '0;
	logic [OVL_W-1:0]  walk_ovl = '0;
	logic [CNT_W-1:0]  walk_switches = '0;
	logic [ITER_W-1:0] walk_level_cnt = '0;
	int                walk_depth = 0;
	status_t           walk_state = ST_IDLE;
	err_t              walk_err = ERR_NONE;
	stk_entry_t        ret_stack [RET_DEPTH];

	walk_req_t pending_reqs [$];
	res_t      expected_walk_res [$];
	walk_req_t next_req;
	res_t      exp_res;
	int        req_gap = 0;
	int        res_stall = 0;
	logic      idle_on = 1'b1;
	int        fail_cnt = 0;
	int        cycle_cnt = 0;

	command_list_overlay_switch_counter #(
		.STACK_DEPTH(RET_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.start_req     (start_req),
		.start_address (start_address),
		.command_word  (command_word),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.fetch_address (fetch_address),
		.switch_count  (switch_count),
		.active_overlay(active_overlay),
		.done_res      (done_res),
		.error_code    (error_code),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Look up the byte length of a command; zero flags an id the walker rejects.
	function automatic int unsigned cmd_bytes(input logic [ID_W-1:0] id);
		logic [127:0] row;
		case (id[7:4])
			4'h0: row = LEN_ROW_0;
			4'h1: row = LEN_ROW_1;
			4'hC: row = LEN_ROW_C;
			4'hD: row = LEN_ROW_D;
			4'hE: row = LEN_ROW_E;
			4'hF: row = LEN_ROW_F;
			default: row = '0;
		endcase
		return 32'(row[(15 - id[3:0]) * 8 +: 8]);
	endfunction

	function automatic void end_walk(input err_t code);
		walk_state = ST_DONE;
		walk_err = code;
	endfunction

	// Advance the shadow walker by one request and return the result it shows.
	function automatic res_t advance_walk(input logic start, input logic [ADDR_W-1:0] addr,
		input logic [WORD_W-1:0] word);
		logic [ID_W-1:0]  id;
		logic [OVL_W-1:0] ov;
		int unsigned      lim;
		int unsigned      sz;
		stk_entry_t       ent;
		res_t             r;
		id = word[31:24];
		lim = (iter_limit_reg == '0) ? 1 : iter_limit_reg;
		if (start) begin
			walk_addr = addr;
			walk_ovl = '0;
			walk_switches = '0;
			walk_depth = 0;
			walk_level_cnt = '0;
			walk_state = ST_WALK;
			walk_err = ERR_NONE;
		end else if (walk_state == ST_WALK) begin
			if (id == ID_JUMP) begin
				walk_addr = word[ADDR_W-1:0];
				walk_level_cnt++;
				if (walk_level_cnt >= lim)
					end_walk(ERR_ITER);
			end else if (id == ID_CALL) begin
				if (walk_depth >= RET_DEPTH) begin
					end_walk(ERR_STACK);
				end else begin
					// the call itself counts at the caller's level
					ent.addr = walk_addr + RET_OFFSET;
					ent.iter = walk_level_cnt + 1'b1;
					ret_stack[walk_depth] = ent;
					walk_depth++;
					walk_level_cnt = '0;
					walk_addr = word[ADDR_W-1:0];
				end
			end else if (id == ID_RET) begin
				if (walk_depth == 0) begin
					end_walk(ERR_NONE);
				end else begin
					walk_depth--;
					ent = ret_stack[walk_depth];
					walk_addr = ent.addr;
					walk_level_cnt = ent.iter;
					if (walk_level_cnt >= lim)
						end_walk(ERR_ITER);
				end
			end else begin
				sz = cmd_bytes(id);
				if (sz == 0) begin
					end_walk(ERR_SIZE);
				end else begin
					ov = id[7:4];
					if (ov > OVL_MAX)
						ov = OVL_MAX;
					walk_addr = walk_addr + sz[ADDR_W-1:0];
					if (ov != '0 && ov != walk_ovl) begin
						walk_ovl = ov;
						if (walk_switches != CNT_MAX)
							walk_switches++;
					end
					walk_level_cnt++;
					if (walk_level_cnt >= lim)
						end_walk(ERR_ITER);
				end
			end
		end
		r.addr = walk_addr;
		r.sw = walk_switches;
		r.ovl = walk_ovl;
		r.done = (walk_state == ST_DONE);
		r.err = r.done ? walk_err : ERR_NONE;
		return r;
	endfunction

	function automatic logic [ID_W-1:0] pick_plain_id();
		logic [ID_W-1:0] id;
		do
			id = 8'($urandom);
		while (cmd_bytes(id) == 0 || id == ID_JUMP || id == ID_CALL || id == ID_RET);
		return id;
	endfunction

	function automatic logic [ID_W-1:0] pick_bad_id();
		logic [ID_W-1:0] id;
		do
			id = 8'($urandom);
		while (cmd_bytes(id) != 0);
		return id;
	endfunction

	task automatic push_req(input logic s, input logic [ADDR_W-1:0] a, input logic [WORD_W-1:0] w);
		walk_req_t item;
		item.start = s;
		item.addr = a;
		item.word = w;
		pending_reqs.push_back(item);
	endtask

	// start_address is noise on a command request and the word is noise on a start
	task automatic push_cmd(input logic [ID_W-1:0] id, input logic [ADDR_W-1:0] low);
		push_req(1'b0, 24'($urandom), {id, low});
	endtask

	task automatic push_start(input logic [ADDR_W-1:0] a);
		push_req(1'b1, a, $urandom);
	endtask

	// Build one walk: mostly legal commands, with calls nested by a tracked depth and
	// a little noise, so that walks get past the first commands before they end.
	task automatic queue_random_walk(input int n_cmds);
		int depth_guess;
		int call_w;
		int r;
		depth_guess = 0;
		call_w = $urandom_range(8, 30);
		if ($urandom_range(0, 3) == 0)
			push_start({16'hFFFF, 8'($urandom)});
		else
			push_start(24'($urandom));
		repeat (n_cmds) begin
			r = $urandom_range(0, 99);
			if (r < call_w) begin
				if (depth_guess < RET_DEPTH || $urandom_range(0, 3) == 0) begin
					push_cmd(ID_CALL, 24'($urandom));
					if (depth_guess < RET_DEPTH)
						depth_guess++;
				end else begin
					push_cmd(pick_plain_id(), 24'($urandom));
				end
			end else if (r < call_w + 12) begin
				if (depth_guess > 0 || $urandom_range(0, 7) == 0) begin
					push_cmd(ID_RET, 24'($urandom));
					if (depth_guess > 0)
						depth_guess--;
				end else begin
					push_cmd(pick_plain_id(), 24'($urandom));
				end
			end else if (r < call_w + 20) begin
				push_cmd(ID_JUMP, 24'($urandom));
			end else if (r < call_w + 21) begin
				push_cmd(pick_bad_id(), 24'($urandom));
			end else if (r < call_w + 23) begin
				push_req($urandom_range(0, 7) == 0, 24'($urandom), $urandom);
			end else begin
				push_cmd(pick_plain_id(), 24'($urandom));
			end
		end
	endtask

	// Hold until every queued request went out and every result came back.
	task automatic wait_drained();
		@(posedge clk);
		while (pending_reqs.size() != 0 || req_valid || expected_walk_res.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Two-phase APB write; the upper data bits are junk the block must drop.
	task automatic write_iter_limit(input logic [ITER_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MAX_ITER;
		pwdata <= {22'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		iter_limit_reg = v;
	endtask

	// Driver: present the next request, hold it until accepted, predict on acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_walk_res.push_back(advance_walk(start_req, start_address, command_word));
				if (idle_on && $urandom_range(0, 5) == 0)
					req_gap = $urandom_range(1, 10);
			end
			if (!req_valid || req_ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					next_req = pending_reqs.pop_front();
					req_valid <= 1'b1;
					start_req <= next_req.start;
					start_address <= next_req.addr;
					command_word <= next_req.word;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest prediction, stall at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_walk_res.size() == 0) begin
					$error("result with no request pending: fetch_address %h", fetch_address);
					fail_cnt++;
				end else begin
					exp_res = expected_walk_res.pop_front();
					if (fetch_address !== exp_res.addr) begin
						$error("fetch_address: expected %h, got %h", exp_res.addr, fetch_address);
						fail_cnt++;
					end
					if (switch_count !== exp_res.sw) begin
						$error("switch_count: expected %0d, got %0d", exp_res.sw, switch_count);
						fail_cnt++;
					end
					if (active_overlay !== exp_res.ovl) begin
						$error("active_overlay: expected %h, got %h", exp_res.ovl, active_overlay);
						fail_cnt++;
					end
					if (done_res !== exp_res.done) begin
						$error("done_res: expected %b, got %b", exp_res.done, done_res);
						fail_cnt++;
					end
					if (error_code !== exp_res.err) begin
						$error("error_code: expected %0d, got %0d", exp_res.err, error_code);
						fail_cnt++;
					end
				end
			end
			if (res_stall > 0)
				res_stall--;
			else if (idle_on && $urandom_range(0, 9) == 0)
				res_stall = $urandom_range(1, 10);
			res_ready <= (res_stall == 0);
		end
	end

	// Watchdog: drop the run if it hangs.
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int base;
		logic [ITER_W-1:0] phase_limits [5];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk under the reset limit.
		// Drop words before any start: the walker is still idle.
		push_cmd(8'h10, 24'($urandom));
		push_cmd(8'hFF, 24'hFFFFFF);
		push_start(24'hFFFFFC);
		push_cmd(8'hCF, 24'h000000);      // advance wraps past the top address
		push_cmd(8'h10, 24'($urandom));   // overlay 1, counted
		push_cmd(8'hD0, 24'($urandom));   // 0xD folds to overlay C, counted
		push_cmd(8'hFF, 24'($urandom));   // still C, not counted
		push_cmd(8'h01, 24'($urandom));   // overlay 0 leaves C selected
		push_cmd(ID_JUMP, 24'hFFFFF8);
		push_cmd(ID_CALL, 24'h000100);    // return address wraps to zero
		push_cmd(8'hC6, 24'($urandom));
		push_cmd(ID_RET, 24'h000000);
		push_cmd(ID_RET, 24'hFFFFFF);     // return at depth zero ends the walk cleanly
		push_cmd(8'h10, 24'($urandom));   // ignored once the walk is over
		push_start(24'h000000);
		push_cmd(8'h00, 24'hFFFFFF);      // unknown id ends with a size error
		push_start(24'($urandom));
		repeat (RET_DEPTH + 1)
			push_cmd(ID_CALL, 24'($urandom));  // last call finds the stack full
		push_cmd(8'hC0, 24'($urandom));

		// Smallest limit: the first command trips it.
		wait_drained();
		write_iter_limit(10'd1);
		push_start(24'($urandom));
		push_cmd(8'h05, 24'($urandom));

		// A call counts at the caller's level; the limit is checked when it returns.
		wait_drained();
		write_iter_limit(10'd2);
		push_start(24'($urandom));
		push_cmd(8'h17, 24'($urandom));
		push_cmd(ID_CALL, 24'($urandom));
		push_cmd(ID_RET, 24'($urandom));

		// Random walks, one limit setting per phase.
		phase_limits[0] = 10'd1023;
		phase_limits[1] = ITER_W'($urandom_range(2, 12));
		phase_limits[2] = ITER_RESET;
		phase_limits[3] = ITER_W'($urandom_range(13, 200));
		phase_limits[4] = 10'd1;
		foreach (phase_limits[p]) begin
			wait_drained();
			write_iter_limit(phase_limits[p]);
			base = pending_reqs.size();
			while (pending_reqs.size() - base < 170)
				queue_random_walk($urandom_range(10, 60));
		end

		// Closing walk, no idling: call bodies that flip between overlay 1 and overlay C.
		wait_drained();
		idle_on = 1'b0;
		write_iter_limit(10'd1023);
		push_start(24'($urandom));
		repeat (4) begin
			push_cmd(ID_CALL, 24'($urandom));
			for (int k = 0; k < 12; k++) begin
				if (k % 2 == 0)
					push_cmd(8'h10 + 8'($urandom_range(0, 12)), 24'($urandom));
				else
					push_cmd(8'($urandom_range(8'hC0, 8'hFF)), 24'($urandom));
			end
			push_cmd(ID_RET, 24'($urandom));
		end
		push_cmd(ID_RET, 24'($urandom));

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
